>>> src/q8bwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q8bwd_pkg
// Shared types and constants of the Q8_0 block weight dequantiser.
// ----------------------------------------------------------------------------
package q8bwd_pkg;

  localparam int unsigned MaxWeights  = 4096;
  localparam int unsigned CountW      = $clog2(MaxWeights) + 1;
  localparam int unsigned IndexW      = $clog2(MaxWeights);
  localparam int unsigned BlockBytes  = 34;
  localparam int unsigned PosW        = 6;
  localparam int unsigned RecipShift  = 18;
  localparam int unsigned Recip34     = (1 << RecipShift) / BlockBytes + 1;
  localparam int unsigned BlockSmall  = (MaxWeights / 32) * BlockBytes;
  localparam logic [31:0] CanonNan    = 32'h7FC0_0000;
  localparam logic [31:0] PosInf      = 32'h7F80_0000;

  typedef enum logic [1:0] {
    KindBlock = 2'd0,
    KindRaw   = 2'd1,
    KindNone  = 2'd2
  } kind_e;

  typedef enum logic [7:0] {
    RegTotalBytes  = 8'd0,
    RegWeightLimit = 8'd1
  } reg_idx_e;

endpackage

>>> src/q8bwd_scale_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q8bwd_scale_mul
// Exact product of a signed byte and an fp16 scale as an IEEE single.
// ----------------------------------------------------------------------------
module q8bwd_scale_mul (
  input  logic [7:0]  q_byte_i,
  input  logic [15:0] scale_i,
  output logic [31:0] word_o
);
  import q8bwd_pkg::*;

  logic        qneg;
  logic [7:0]  qmag;
  logic        sgn;
  logic [4:0]  ex;
  logic [9:0]  man;
  logic [10:0] mant;
  logic [17:0] prod;
  logic [4:0]  lead;
  logic [17:0] norm;
  logic [7:0]  exp_out;

  always_comb begin
    qneg = q_byte_i[7];
    qmag = qneg ? 8'(8'd0 - q_byte_i) : q_byte_i;
    sgn  = qneg ^ scale_i[15];
    ex   = scale_i[14:10];
    man  = scale_i[9:0];
    mant = (ex == 5'd0) ? {1'b0, man} : {1'b1, man};
    prod = 18'(qmag * mant);
    lead = 5'd0;
    for (int i = 0; i < 18; i++) begin
      if (prod[i]) begin
        lead = 5'(i);
      end
    end
    norm = prod << (5'd17 - lead);
    if (ex == 5'd0) begin
      exp_out = 8'(lead) + 8'd103;
    end else begin
      exp_out = 8'(lead) + 8'(ex) + 8'd102;
    end
    if (ex == 5'h1F) begin
      if (man != 10'd0 || qmag == 8'd0) begin
        word_o = CanonNan;
      end else begin
        word_o = {sgn, 31'd0} | PosInf;
      end
    end else if (prod == 18'd0) begin
      word_o = {sgn, 31'd0};
    end else begin
      word_o = {sgn, exp_out, norm[16:0], 6'd0};
    end
  end

endmodule

>>> src/q8_block_weight_dequantizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q8_block_weight_dequantizer_core
// Decodes a byte stream of Q8_0 blocks or raw float words into weights.
// ----------------------------------------------------------------------------
// a weight is registered and appears in the cycle after the byte that completes it
// throughput: one byte per cycle, limited only by the output register
// a write of total_bytes is decoded into format and count in that cycle
// reset: total_bytes 0, weight_limit 1024, stream state cleared
module q8_block_weight_dequantizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] weight_bits_o,
  output logic [11:0] weight_index_o,
  output logic        is_last_o,
  output logic        format_kind_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import q8bwd_pkg::*;

  logic [31:0]       total_bytes_q;
  logic [12:0]       weight_limit_q;
  kind_e             kind_q, kind_d;
  logic [CountW-1:0] ncap_q, ncap_d;
  logic [31:0]       byte_offset_q, byte_offset_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [15:0]       scale_q, scale_d;
  logic [23:0]       partial_q, partial_d;
  logic [CountW-1:0] emitted_q, emitted_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       weight_bits_q;
  logic [11:0]       weight_index_q;
  logic              is_last_q, format_kind_q;

  logic              in_acc, cfg_wr, active, have, emit;
  logic [CountW-1:0] lim_eff, total_w;
  logic [31:0]       word, block_word;
  logic [PosW-1:0]   p_blk;
  logic [1:0]        p_raw;
  logic [9:0]        s1;
  logic [8:0]        s2, s3;
  logic [5:0]        v17;
  logic [25:0]       kprod;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;

  // format and weight count decoded from the written byte length
  always_comb begin
    s1 = 10'(cfg_data_i[7:0]) + 10'(cfg_data_i[15:8])
       + 10'(cfg_data_i[23:16]) + 10'(cfg_data_i[31:24]);
    s2 = 9'(s1[7:0]) + 9'(s1[9:8]);
    s3 = 9'(s2[7:0]) + 9'(s2[8]);
    v17 = 6'(s3[3:0]) + 6'(s3[8]) - 6'(s3[7:4]);
    kprod = 26'(cfg_data_i[12:0] * 13'(Recip34));
    if (!cfg_data_i[0] && v17 == 6'd0) begin
      kind_d = KindBlock;
      if (cfg_data_i < 32'(BlockSmall)) begin
        ncap_d = CountW'({kprod[RecipShift+6:RecipShift], 5'd0});
      end else begin
        ncap_d = CountW'(MaxWeights);
      end
    end else if (cfg_data_i[1:0] == 2'd0) begin
      kind_d = KindRaw;
      if (cfg_data_i[31:2] >= 30'(MaxWeights)) begin
        ncap_d = CountW'(MaxWeights);
      end else begin
        ncap_d = CountW'(cfg_data_i[31:2]);
      end
    end else begin
      kind_d = KindNone;
      ncap_d = '0;
    end
  end

  q8bwd_scale_mul u_mul (
    .q_byte_i (data_byte_i),
    .scale_i  (scale_q),
    .word_o   (block_word)
  );

  always_comb begin
    lim_eff = (weight_limit_q > 13'(MaxWeights)) ? CountW'(MaxWeights)
                                                 : CountW'(weight_limit_q);
    total_w = (ncap_q < lim_eff) ? ncap_q : lim_eff;
    active  = (byte_offset_q < total_bytes_q) && (kind_q != KindNone);

    byte_offset_d = byte_offset_q;
    pos_d         = pos_q;
    scale_d       = scale_q;
    partial_d     = partial_q;
    emitted_d     = emitted_q;
    have          = 1'b0;
    word          = block_word;
    p_blk         = (pos_q >= PosW'(BlockBytes)) ? '0 : pos_q;
    p_raw         = pos_q[1:0];

    if (active) begin
      byte_offset_d = byte_offset_q + 32'd1;
      if (kind_q == KindBlock) begin
        if (p_blk == PosW'(0)) begin
          scale_d = {scale_q[15:8], data_byte_i};
        end else if (p_blk == PosW'(1)) begin
          scale_d = {data_byte_i, scale_q[7:0]};
        end else begin
          have = 1'b1;
        end
        pos_d = (p_blk == PosW'(BlockBytes - 1)) ? '0 : p_blk + PosW'(1);
      end else begin
        case (p_raw)
          2'd0:    partial_d[7:0]   = data_byte_i;
          2'd1:    partial_d[15:8]  = data_byte_i;
          2'd2:    partial_d[23:16] = data_byte_i;
          default: begin
            word      = {data_byte_i, partial_q};
            partial_d = '0;
            have      = 1'b1;
          end
        endcase
        pos_d = PosW'(2'(p_raw + 2'd1));
      end
    end
    emit = have && (emitted_q < total_w);
    if (emit) begin
      emitted_d = emitted_q + CountW'(1);
    end

    if (in_acc) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_bytes_q  <= '0;
      weight_limit_q <= 13'd1024;
      kind_q         <= KindBlock;
      ncap_q         <= '0;
      byte_offset_q  <= '0;
      pos_q          <= '0;
      scale_q        <= '0;
      partial_q      <= '0;
      emitted_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_wr && cfg_index_i == RegTotalBytes) begin
        total_bytes_q <= cfg_data_i;
        kind_q        <= kind_d;
        ncap_q        <= ncap_d;
        byte_offset_q <= '0;
        pos_q         <= '0;
        scale_q       <= '0;
        partial_q     <= '0;
        emitted_q     <= '0;
      end else if (in_acc) begin
        byte_offset_q <= byte_offset_d;
        pos_q         <= pos_d;
        scale_q       <= scale_d;
        partial_q     <= partial_d;
        emitted_q     <= emitted_d;
      end
      if (cfg_wr && cfg_index_i == RegWeightLimit) begin
        weight_limit_q <= cfg_data_i[12:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      weight_bits_q  <= word;
      weight_index_q <= emitted_q[IndexW-1:0];
      is_last_q      <= (emitted_q + CountW'(1)) == total_w;
      format_kind_q  <= (kind_q == KindRaw);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign weight_bits_o  = weight_bits_q;
  assign weight_index_o = weight_index_q;
  assign is_last_o      = is_last_q;
  assign format_kind_o  = format_kind_q;

  a_rise_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_i && !in_stall_o))
    else $error("weight without accepted item");

  a_past_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cfg_wr && byte_offset_q >= total_bytes_q) |=> $stable(emitted_q))
    else $error("count moved past end of tensor");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PosW'(BlockBytes))
    else $error("block position out of range");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the Q8_0 block weight dequantiser against a behavioural decoder:
// block and raw word tensors, odd sizes, limits and special scales.
// ----------------------------------------------------------------------------
module tb;
  import q8bwd_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] weight_bits_o;
  logic [11:0] weight_index_o;
  logic        is_last_o;
  logic        format_kind_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  typedef struct packed {
    logic [31:0] bits;
    logic [11:0] idx;
    logic        last;
    logic        kind;
  } weight_t;

  weight_t     weight_q[$];
  int          n_errors;
  int          n_items;
  int          n_weights;
  int          tensor_cnt;
  int          idle_cycles;
  bit          quiet;
  int          stall_run;

  logic [31:0] m_total;
  logic [12:0] m_limit;
  logic [31:0] m_offset;
  logic [5:0]  m_pos;
  logic [15:0] m_scale;
  logic [23:0] m_partial;
  logic [12:0] m_emitted;

  q8_block_weight_dequantizer_core u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] dequant(logic [7:0] qb, logic [15:0] h);
    logic [7:0]  qmag;
    logic [31:0] sgn;
    logic [4:0]  ex;
    logic [10:0] mant;
    int          e2;
    logic [31:0] prod;
    int          t;
    qmag = qb[7] ? 8'(-qb) : qb;
    sgn  = {qb[7] ^ h[15], 31'b0};
    ex   = h[14:10];
    if (ex == 5'h1F) begin
      if (h[9:0] != 0 || qmag == 0) return CanonNan;
      return sgn | PosInf;
    end
    if (ex == 0) begin
      mant = {1'b0, h[9:0]};
      e2   = -24;
    end else begin
      mant = {1'b1, h[9:0]};
      e2   = int'(ex) - 25;
    end
    prod = qmag * mant;
    if (prod == 0) return sgn;
    t = 17;
    while (!prod[t]) t--;
    return sgn | (32'(t + e2 + 127) << 23) | ((prod << (23 - t)) & 32'h7FFFFF);
  endfunction

  function automatic logic [1:0] tensor_kind();
    if (m_total % BlockBytes == 0) return KindBlock;
    if (m_total % 4 == 0) return KindRaw;
    return KindNone;
  endfunction

  function automatic logic [31:0] weight_count(logic [1:0] k);
    longint lim;
    longint n;
    lim = (m_limit > MaxWeights) ? MaxWeights : m_limit;
    if (k == KindBlock) n = longint'(m_total / BlockBytes) * 32;
    else if (k == KindRaw) n = m_total / 4;
    else n = 0;
    return 32'(n < lim ? n : lim);
  endfunction

  task automatic predict_byte(logic [7:0] b);
    logic [1:0]  k;
    logic [31:0] tot;
    logic [31:0] w;
    bit          have;
    int          p;
    k    = tensor_kind();
    tot  = weight_count(k);
    have = 0;
    if (m_offset >= m_total || k == KindNone) return;
    m_offset++;
    if (k == KindBlock) begin
      p = (m_pos >= BlockBytes) ? 0 : m_pos;
      if (p == 0) m_scale = {8'h00, b};
      else if (p == 1) m_scale[15:8] = b;
      else begin
        w    = dequant(b, m_scale);
        have = 1;
      end
      p++;
      m_pos = (p == BlockBytes) ? 0 : 6'(p);
    end else begin
      p = m_pos & 3;
      if (p < 3) m_partial[8*p +: 8] = b;
      else begin
        w         = {b, m_partial};
        m_partial = '0;
        have      = 1;
      end
      m_pos = 6'((p + 1) & 3);
    end
    if (!have || m_emitted >= tot) return;
    weight_q.push_back('{w, m_emitted[11:0], (m_emitted + 1 == tot), k[0]});
    m_emitted++;
  endtask

  task automatic idle_gap();
    if (!quiet) begin
      while ($urandom_range(99) < 24) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    idle_gap();
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(b);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (weight_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == RegTotalBytes) begin
      m_total   = val;
      m_offset  = '0;
      m_pos     = '0;
      m_scale   = '0;
      m_partial = '0;
      m_emitted = '0;
      tensor_cnt++;
    end else begin
      m_limit = val[12:0];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_block(logic [15:0] scale, int kind_of_data);
    send_byte(scale[7:0]);
    send_byte(scale[15:8]);
    for (int i = 0; i < 32; i++) begin
      case (kind_of_data)
        0: send_byte(8'(i * 8 - 128));
        1: send_byte(i[0] ? 8'h80 : 8'h7F);
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  task automatic test_special_scales();
    write_reg(RegWeightLimit, 32'd4096);
    write_reg(RegTotalBytes, 32'd34 * 6);
    send_block(16'h3C00, 0);
    send_block(16'h03FF, 1);
    send_block(16'h7C00, 0);
    send_block(16'hFC01, 2);
    send_block(16'h8000, 1);
    send_block(16'h7BFF, 1);
    send_byte(8'h55);
  endtask

  task automatic test_raw_and_odd_sizes();
    write_reg(RegTotalBytes, 32'd0);
    send_byte(8'hAA);
    write_reg(RegTotalBytes, 32'd7);
    repeat (3) send_byte(8'($urandom));
    write_reg(RegTotalBytes, 32'd12);
    for (int i = 0; i < 13; i++) send_byte(i[0] ? 8'hFF : 8'h00);
  endtask

  task automatic test_limits();
    write_reg(RegWeightLimit, 32'd0);
    write_reg(RegTotalBytes, 32'd34);
    send_block(16'h3C00, 2);
    write_reg(RegWeightLimit, 32'h1FFF);
    write_reg(RegTotalBytes, 32'd68);
    send_block(16'h4000, 2);
    write_reg(RegWeightLimit, 32'd40);
    send_block(16'h4000, 2);
    write_reg(RegWeightLimit, 32'd1);
    write_reg(RegTotalBytes, 32'hFFFF_FFFC);
    repeat (8) send_byte(8'($urandom));
    write_reg(RegTotalBytes, 32'hFFFF_FFFF);
    send_byte(8'h01);
  endtask

  task automatic test_random_tensors();
    int sent;
    int n;
    sent = 0;
    while (sent < 560) begin
      write_reg(RegWeightLimit, ($urandom_range(9) == 0) ? 32'($urandom_range(1, 60))
                                                        : 32'($urandom_range(0, 8191)));
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: n = 34 * $urandom_range(1, 4);
        6, 7:             n = 4 * $urandom_range(1, 30);
        8:                n = $urandom_range(1, 60);
        default:          n = 34 * 4 - $urandom_range(0, 40);
      endcase
      write_reg(RegTotalBytes, n);
      quiet = (sent > 200 && sent < 350);
      n += $urandom_range(3) == 0 ? $urandom_range(1, 6) : 0;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(5) == 0 && i % 34 < 2) send_byte(8'($urandom) & 8'h83);
        else send_byte(8'($urandom));
      end
      sent += n;
      if (sent > 400 && sent < 500) drain();
    end
    quiet = 0;
  endtask

  always @(negedge clk_i) begin
    if (stall_run > 0) begin
      stall_run--;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(99) < 11) begin
      stall_run = $urandom_range(3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    weight_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_weights++;
      if (weight_q.size() == 0) begin
        n_errors++;
        $display("%0t unexpected weight: actual %h idx %0d", $time, weight_bits_o,
                 weight_index_o);
      end else begin
        e = weight_q.pop_front();
        if (e.bits !== weight_bits_o || e.idx !== weight_index_o ||
            e.last !== is_last_o || e.kind !== format_kind_o) begin
          n_errors++;
          $display("%0t weight: expected %h/%0d/%b/%b actual %h/%0d/%b/%b", $time,
                   e.bits, e.idx, e.last, e.kind, weight_bits_o, weight_index_o,
                   is_last_o, format_kind_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > 2000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    n_errors = 0; n_items = 0; n_weights = 0; tensor_cnt = 0;
    idle_cycles = 0; quiet = 0; stall_run = 0;
    m_total = '0; m_limit = 13'd1024;
    m_offset = '0; m_pos = '0; m_scale = '0; m_partial = '0; m_emitted = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    repeat (34) send_byte(8'h11);
    test_special_scales();
    test_raw_and_odd_sizes();
    test_limits();
    test_random_tensors();
    drain();
    repeat (10) @(negedge clk_i);
    $display("covered %0d bytes over %0d tensors, %0d weights checked", n_items,
             tensor_cnt, n_weights);
    if (n_errors == 0 && weight_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
